// File: src/bsfr_pkg.sv
// ----------------------------------------------------------------------------
// bsfr_pkg
// Shared types and constants for the byte-stuffed frame receiver.
// ----------------------------------------------------------------------------
package bsfr_pkg;

   // Receive modes of the deframer
   typedef enum logic [1:0] {
      MODE_WAIT    = 2'd0,
      MODE_COLLECT = 2'd1,
      MODE_ESCAPE  = 2'd2
   } mode_type;

   // Configuration register indexes
   localparam logic [2:0] CSR_FLAG_BYTE    = 3'd0;
   localparam logic [2:0] CSR_ESCAPE_BYTE  = 3'd1;
   localparam logic [2:0] CSR_ESCAPE_MASK  = 3'd2;
   localparam logic [2:0] CSR_CHECK_ENABLE = 3'd3;
   localparam logic [2:0] CSR_SEQ_ENABLE   = 3'd4;

   localparam int unsigned IDX_W     = 6;
   localparam int unsigned OUT_LIMIT = 64;
   localparam int unsigned CNT_EXT_W = 9;
   localparam logic [7:0]  LAST_SEQ_RESET = 8'd255;

   // Frame command handed from front to back
   typedef struct packed {
      logic             bad;
      logic             bank;
      logic [IDX_W-1:0] last_idx;
      logic             gap;
   } cmd_type;

   // Back reports a bank drained
   typedef struct packed {
      logic done;
      logic bank;
   } drain_type;

endpackage

// File: src/bsfr_ram.sv
// ----------------------------------------------------------------------------
// bsfr_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bsfr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and read with hold when not enabled
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/bsfr_front.sv
// ----------------------------------------------------------------------------
// bsfr_front
// Deframer front end: holds configuration, unstuffs bytes into the frame
// store and issues one command per closed non-empty frame.
// ----------------------------------------------------------------------------
module bsfr_front import bsfr_pkg::*; #(
   parameter int unsigned MAX_FRAME = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [2:0]                     csr_index,
   input  logic [7:0]                     csr_data,
   output logic                           ram_we,
   output logic [$clog2(MAX_FRAME):0]     ram_waddr,
   output logic [7:0]                     ram_wdata,
   output logic                           cmd_push,
   output cmd_type                        cmd_data,
   input  logic                           cmd_full,
   input  drain_type                      drain
);

   localparam int unsigned AW = $clog2(MAX_FRAME);
   localparam int unsigned CW = $clog2(MAX_FRAME + 1);

   logic [7:0]    flag_byte_ff, escape_byte_ff, escape_mask_ff;
   logic          check_enable_ff, seq_enable_ff;
   mode_type      mode_ff, mode_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    sum_ff, sum_in;
   logic [7:0]    last_seq_ff, last_seq_in;
   logic          bank_ff, bank_in;
   logic [1:0]    busy_ff, busy_in;
   logic [7:0]    seq_byte_ff;
   logic          accept;
   logic          store_req;
   logic [7:0]    store_val;
   logic          store_ok;
   logic [CNT_EXT_W-1:0] count_ext;

   assign accept    = req_tvalid && req_tready;
   assign req_tready = !cmd_full && !busy_ff[bank_ff];
   assign csr_ready = 1'b1;
   assign count_ext = CNT_EXT_W'(count_ff);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         flag_byte_ff    <= 8'd126;
         escape_byte_ff  <= 8'd125;
         escape_mask_ff  <= 8'd32;
         check_enable_ff <= 1'b1;
         seq_enable_ff   <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FLAG_BYTE:    flag_byte_ff    <= csr_data;
            CSR_ESCAPE_BYTE:  escape_byte_ff  <= csr_data;
            CSR_ESCAPE_MASK:  escape_mask_ff  <= csr_data;
            CSR_CHECK_ENABLE: check_enable_ff <= csr_data[0];
            CSR_SEQ_ENABLE:   seq_enable_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Decode the accepted byte
   always_comb begin
      mode_in     = mode_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      last_seq_in = last_seq_ff;
      bank_in     = bank_ff;
      store_req   = 1'b0;
      store_val   = req_tdata;
      cmd_push    = 1'b0;
      cmd_data    = '0;
      if (accept) begin
         unique case (mode_ff)
            MODE_WAIT: begin
               if (req_tdata == flag_byte_ff) begin
                  mode_in  = MODE_COLLECT;
                  count_in = '0;
                  sum_in   = '0;
               end
            end
            MODE_COLLECT: begin
               if (req_tdata == flag_byte_ff) begin
                  // Close the frame, then open a new one
                  if (count_ff != '0) begin
                     cmd_push = 1'b1;
                     if (check_enable_ff && sum_ff != 8'd0) begin
                        cmd_data.bad = 1'b1;
                     end else begin
                        cmd_data.bank = bank_ff;
                        cmd_data.last_idx = (count_ext > CNT_EXT_W'(OUT_LIMIT)) ?
                           IDX_W'(OUT_LIMIT - 1) : IDX_W'(count_ext - 1'b1);
                        if (seq_enable_ff) begin
                           cmd_data.gap = (8'(last_seq_ff + 8'd1) != seq_byte_ff);
                           last_seq_in  = seq_byte_ff;
                        end
                        bank_in = !bank_ff;
                     end
                  end
                  count_in = '0;
                  sum_in   = '0;
               end else if (req_tdata == escape_byte_ff) begin
                  mode_in = MODE_ESCAPE;
               end else begin
                  store_req = 1'b1;
               end
            end
            MODE_ESCAPE: begin
               mode_in = MODE_COLLECT;
               if (req_tdata == flag_byte_ff) begin
                  count_in = '0;
                  sum_in   = '0;
               end else begin
                  store_req = 1'b1;
                  store_val = req_tdata ^ escape_mask_ff;
               end
            end
            default: mode_in = MODE_WAIT;
         endcase
      end
      // Store a byte or drop an overlong frame
      store_ok = store_req && (count_ext < CNT_EXT_W'(MAX_FRAME));
      if (store_req && !store_ok) begin
         mode_in = MODE_WAIT;
      end
      if (store_ok) begin
         count_in = count_ff + 1'b1;
         sum_in   = sum_ff + store_val;
      end
   end

   assign ram_we    = store_ok;
   assign ram_waddr = {bank_ff, count_ff[AW-1:0]};
   assign ram_wdata = store_val;

   // Track banks still being drained
   always_comb begin
      busy_in = busy_ff;
      if (drain.done) begin
         busy_in[drain.bank] = 1'b0;
      end
      if (cmd_push && !cmd_data.bad) begin
         busy_in[bank_ff] = 1'b1;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_WAIT;
         count_ff    <= '0;
         sum_ff      <= '0;
         last_seq_ff <= LAST_SEQ_RESET;
         bank_ff     <= 1'b0;
         busy_ff     <= '0;
      end else begin
         mode_ff     <= mode_in;
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         last_seq_ff <= last_seq_in;
         bank_ff     <= bank_in;
         busy_ff     <= busy_in;
      end
   end

   // Keep a copy of frame entry 1 for the sequence check
   always_ff @(posedge clock) begin
      if (store_ok && count_ff == CW'(1)) begin
         seq_byte_ff <= store_val;
      end
   end

endmodule

// File: src/bsfr_queue.sv
// ----------------------------------------------------------------------------
// bsfr_queue
// Two-entry command queue between front end and back end.
// ----------------------------------------------------------------------------
module bsfr_queue import bsfr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff;

   assign full  = (fill_ff == 2'd2);
   assign empty = (fill_ff == 2'd0);
   assign head  = entry_ff[rd_ptr_ff];

   // Hold entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// File: src/bsfr_back.sv
// ----------------------------------------------------------------------------
// bsfr_back
// Back end: drains a stored frame one byte per cycle unless stalled, or sends
// the single checksum error item, with the RAM read register as output stage.
// ----------------------------------------------------------------------------
module bsfr_back import bsfr_pkg::*; #(
   parameter int unsigned MAX_FRAME = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_empty,
   input  cmd_type                    cmd_head,
   output logic                       cmd_pop,
   output drain_type                  drain,
   output logic                       ram_re,
   output logic [$clog2(MAX_FRAME):0] ram_raddr,
   input  logic [7:0]                 ram_rdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [15:0]                rsp_tdata,
   output logic                       rsp_tlast,
   output logic [1:0]                 rsp_tuser
);

   localparam int unsigned AW = $clog2(MAX_FRAME);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [IDX_W-1:0] out_idx_ff;
   logic             out_last_ff, out_bad_ff, out_gap_ff;
   logic             issue;
   logic             is_last;

   // Issue when the output stage is free or being taken
   assign issue   = !cmd_empty && (!valid_ff || rsp_tready);
   assign is_last = (idx_ff == cmd_head.last_idx);
   assign ram_re    = issue && !cmd_head.bad;
   assign ram_raddr = {cmd_head.bank, AW'(idx_ff)};
   assign cmd_pop   = issue && (cmd_head.bad || is_last);
   assign drain.done = issue && !cmd_head.bad && is_last;
   assign drain.bank = cmd_head.bank;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (issue) begin
         valid_in = 1'b1;
         if (!cmd_head.bad) begin
            idx_in = is_last ? '0 : idx_ff + 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Item side fields alongside the RAM read register
   always_ff @(posedge clock) begin
      if (issue) begin
         out_bad_ff  <= cmd_head.bad;
         out_idx_ff  <= cmd_head.bad ? '0 : idx_ff;
         out_last_ff <= cmd_head.bad || is_last;
         out_gap_ff  <= !cmd_head.bad && is_last && cmd_head.gap;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, out_idx_ff, (out_bad_ff ? 8'd0 : ram_rdata)};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = {out_gap_ff, out_bad_ff};

endmodule

// File: src/byte_stuffed_frame_receiver.sv
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver
// Byte-stuffed frame receiver: unstuffs frames, checks sum and sequence.
// ----------------------------------------------------------------------------
// The receiver takes one raw byte per cycle on req_ while its frame store
// bank and command queue have room. Frames are collected into one of two RAM
// banks; a closing flag hands the frame to the drain side, which emits one
// byte per cycle on rsp_ while rsp_tready allows, with tlast on the last
// byte, or one error item when the checksum fails. The front end stalls a
// byte only while both banks hold frames not yet fully read out, or the
// two-entry command queue is full, so sustained throughput is one byte per
// cycle apart from that read-out. Configuration must be written only while
// the block is idle (not enforced by the block); csr_ready is always high.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_receiver import bsfr_pkg::*; #(
   parameter int unsigned MAX_FRAME = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] frame_byte, [13:8] byte_index, [15:14] zero
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser,   // [0] checksum_bad, [1] seq_gap
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);

   localparam int unsigned AW = $clog2(MAX_FRAME);

   logic          ram_we, ram_re;
   logic [AW:0]   ram_waddr, ram_raddr;
   logic [7:0]    ram_wdata, ram_rdata;
   logic          cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type       cmd_data, cmd_head;
   drain_type     drain;

   bsfr_front #(.MAX_FRAME(MAX_FRAME)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .cmd_push   (cmd_push),
      .cmd_data   (cmd_data),
      .cmd_full   (cmd_full),
      .drain      (drain)
   );

   bsfr_ram #(.WIDTH(8), .DEPTH(2 << AW)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   bsfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .head      (cmd_head)
   );

   bsfr_back #(.MAX_FRAME(MAX_FRAME)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_empty  (cmd_empty),
      .cmd_head   (cmd_head),
      .cmd_pop    (cmd_pop),
      .drain      (drain),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the byte-stuffed frame receiver.
// ----------------------------------------------------------------------------
// Raw link bytes go in on req_. Every accepted byte is run through a local
// deframer that tracks the mode, frame buffer, checksum and sequence number.
// The unstuffed bytes and error items that it predicts queue up and are
// compared field by field with each rsp_ transaction. Directed tests cover
// stuffing, aborts, empty and one-byte frames, checksum and sequence errors
// and register extremes. Random traffic follows under three back-pressure
// mixes, each with its own register settings.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bsfr_pkg::*;

   localparam int FRAME_MAX    = 64;
   localparam int DRAIN_CYCLES = 24;
   localparam int STALL_LIMIT  = 3000;
   localparam int PRINT_LIMIT  = 40;

   typedef logic [7:0] byte_q_type[$];

   typedef struct packed {
      logic [7:0] frame_byte;
      logic [5:0] byte_index;
      logic       last_of_frame;
      logic       checksum_bad;
      logic       seq_gap;
   } frame_item_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // [7:0] frame_byte, [13:8] byte_index, [15:14] zero
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;    // [0] checksum_bad, [1] seq_gap
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [7:0]  csr_data;

   // Local copy of the registers
   logic [7:0] cfg_flag  = 8'd126;
   logic [7:0] cfg_esc   = 8'd125;
   logic [7:0] cfg_mask  = 8'd32;
   logic       cfg_check = 1'b1;
   logic       cfg_seq   = 1'b1;

   // Local copy of the deframer state
   mode_type   rx_mode_m    = MODE_WAIT;
   logic [6:0] stored_count = '0;
   logic [7:0] frame_buf[FRAME_MAX];
   logic [7:0] sum_acc      = '0;
   logic [7:0] seq_last     = LAST_SEQ_RESET;

   frame_item_type unread_items[$];
   int          bytes_taken   = 0;
   int          mismatches    = 0;
   int          idle_cycles   = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;

   byte_stuffed_frame_receiver #(.MAX_FRAME(FRAME_MAX)) dut (.*);

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void open_frame();
      stored_count = '0;
      sum_acc      = '0;
   endfunction

   // Store one unstuffed byte; drop the frame once it outgrows the buffer
   function automatic void store_frame_byte(input logic [7:0] b);
      if (stored_count >= FRAME_MAX) begin
         rx_mode_m = MODE_WAIT;
         return;
      end
      frame_buf[stored_count[5:0]] = b;
      stored_count++;
      sum_acc += b;
   endfunction

   // Closing flag: queue either the frame bytes or a single error item
   function automatic void close_frame();
      frame_item_type it;
      logic        gap;
      logic [7:0]  seq_next;
      gap = 1'b0;
      if (stored_count == 0) return;
      if (cfg_check && sum_acc != 8'd0) begin
         it = '{frame_byte: 8'd0, byte_index: 6'd0, last_of_frame: 1'b1,
                checksum_bad: 1'b1, seq_gap: 1'b0};
         unread_items.push_back(it);
         return;
      end
      if (cfg_seq) begin
         seq_next = seq_last + 8'd1;
         gap      = (seq_next != frame_buf[1]);
         seq_last = frame_buf[1];
      end
      for (int k = 0; k < stored_count; k++) begin
         it.frame_byte    = frame_buf[k];
         it.byte_index    = 6'(k);
         it.last_of_frame = (k == stored_count - 1);
         it.checksum_bad  = 1'b0;
         it.seq_gap       = (k == stored_count - 1) ? gap : 1'b0;
         unread_items.push_back(it);
      end
   endfunction

   // Advance the deframer by one received byte
   function automatic void deframe_byte(input logic [7:0] d);
      if (rx_mode_m != MODE_WAIT || d == cfg_flag) bytes_taken++;
      case (rx_mode_m)
         MODE_COLLECT: begin
            if (d == cfg_flag) begin
               close_frame();
               open_frame();
            end else if (d == cfg_esc) begin
               rx_mode_m = MODE_ESCAPE;
            end else begin
               store_frame_byte(d);
            end
         end
         MODE_ESCAPE: begin
            rx_mode_m = MODE_COLLECT;
            if (d == cfg_flag) open_frame();
            else store_frame_byte(d ^ cfg_mask);
         end
         default: begin
            rx_mode_m = MODE_WAIT;
            if (d == cfg_flag) begin
               open_frame();
               rx_mode_m = MODE_COLLECT;
            end
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("%0t ns: %s got %0d, expected %0d", $time, what, got, want);
   endtask

   // Compare each result transaction with the oldest queued item
   always @(posedge clock) begin
      frame_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (unread_items.size() == 0) begin
            report_mismatch("unexpected result, frame_byte", rsp_tdata[7:0], -1);
         end else begin
            want = unread_items.pop_front();
            if (rsp_tdata[7:0] != want.frame_byte)
               report_mismatch("frame_byte", rsp_tdata[7:0], want.frame_byte);
            if (rsp_tdata[13:8] != want.byte_index)
               report_mismatch("byte_index", rsp_tdata[13:8], want.byte_index);
            if (rsp_tlast != want.last_of_frame)
               report_mismatch("last_of_frame", rsp_tlast, want.last_of_frame);
            if (rsp_tuser[0] != want.checksum_bad)
               report_mismatch("checksum_bad", rsp_tuser[0], want.checksum_bad);
            if (rsp_tuser[1] != want.seq_gap)
               report_mismatch("seq_gap", rsp_tuser[1], want.seq_gap);
         end
      end
   end

   // Receiver back-pressure
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: give up after a long run of cycles with no transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   // Send one raw byte; called and returning at a falling edge
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      deframe_byte(b);
      @(negedge clock);
   endtask

   // Send one frame byte, escaping it when it clashes and now and then anyway
   task automatic send_stuffed(input logic [7:0] b);
      if (b == cfg_flag || b == cfg_esc || $urandom_range(15) == 0) begin
         send_byte(cfg_esc);
         send_byte(b ^ cfg_mask);
      end else begin
         send_byte(b);
      end
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FLAG_BYTE:    cfg_flag  = val;
         CSR_ESCAPE_BYTE:  cfg_esc   = val;
         CSR_ESCAPE_MASK:  cfg_mask  = val;
         CSR_CHECK_ENABLE: cfg_check = val[0];
         CSR_SEQ_ENABLE:   cfg_seq   = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [7:0] flag, input logic [7:0] esc,
                             input logic [7:0] mask, input logic check,
                             input logic seq);
      write_reg(CSR_FLAG_BYTE, flag);
      write_reg(CSR_ESCAPE_BYTE, esc);
      write_reg(CSR_ESCAPE_MASK, mask);
      write_reg(CSR_CHECK_ENABLE, {7'd0, check});
      write_reg(CSR_SEQ_ENABLE, {7'd0, seq});
   endtask

   // Hold the sender, let every result drain and the pipeline settle
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (unread_items.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Random frame body, optionally with a zero sum and the next sequence number
   function automatic byte_q_type make_body(input int len, input bit fix_sum,
                                            input bit in_order);
      byte_q_type body;
      logic [7:0] total;
      int         fix_at;
      total  = 8'd0;
      fix_at = (len > 2) ? len - 1 : 0;
      for (int k = 0; k < len; k++) body.push_back(8'($urandom));
      if (len > 1 && in_order) body[1] = seq_last + 8'd1;
      if (fix_sum) begin
         foreach (body[k]) if (k != fix_at) total += body[k];
         body[fix_at] = -total;
      end
      return body;
   endfunction

   // Open (unless an empty frame is already open), stuff the body, close
   task automatic send_frame(input int len, input bit fix_sum, input bit in_order);
      byte_q_type body;
      if (!(rx_mode_m == MODE_COLLECT && stored_count == 0)) send_byte(cfg_flag);
      body = make_body(len, fix_sum, in_order);
      foreach (body[k]) send_stuffed(body[k]);
      send_byte(cfg_flag);
   endtask

   // ---------------------------------------------------------------- tests

   // A plain frame with the reset register values
   task automatic test_default_frames();
      send_byte(cfg_flag);
      send_byte(8'h05);
      send_byte(8'h00);
      send_byte(8'hFB);
      send_byte(cfg_flag);
   endtask

   // Empty frame, escaped flag and escape, escape of an escape, abort, bad sum
   task automatic test_stuffing_and_aborts();
      logic [7:0] seq_next;
      logic [7:0] fix;
      seq_next = seq_last + 8'd1;
      fix = -(cfg_flag + seq_next + (cfg_esc ^ cfg_mask) + cfg_esc);
      send_byte(cfg_flag);
      send_byte(cfg_esc);
      send_byte(cfg_flag ^ cfg_mask);
      send_byte(seq_next);
      send_byte(cfg_esc);
      send_byte(cfg_esc);
      send_byte(cfg_esc);
      send_byte(cfg_esc ^ cfg_mask);
      send_stuffed(fix);
      send_byte(cfg_flag);
      // abort on flag after escape, then a frame with a bad sum
      send_byte(8'h11);
      send_byte(cfg_esc);
      send_byte(cfg_flag);
      send_byte(8'h22);
      send_byte(8'h33);
      send_byte(cfg_flag);
   endtask

   // One-byte frame (stale sequence byte) and an out-of-order sequence number
   task automatic test_short_frames();
      send_byte(8'h00);
      send_byte(cfg_flag);
      send_frame(3, 1'b1, 1'b0);
   endtask

   // Extreme register values: flag 0, escape 255, no mask, no checks
   task automatic test_register_extremes();
      wait_quiet();
      set_config(8'h00, 8'hFF, 8'h00, 1'b0, 1'b0);
      send_frame(4, 1'b0, 1'b0);
      send_frame(2, 1'b0, 1'b1);
   endtask

   // Mostly well-formed frames with random content; some noise and breakage
   task automatic test_random_traffic(input int phase, input int quota);
      int first;
      int kind;
      int n;
      first = bytes_taken;
      n     = 0;
      while (bytes_taken - first < quota) begin
         kind = $urandom_range(99);
         if (n == 0 && phase == 1) begin
            send_frame(66, 1'b1, 1'b1);
         end else if (n == 0 && phase == 2) begin
            send_frame(FRAME_MAX, 1'b1, 1'b1);
         end else if (kind < 65) begin
            send_frame($urandom_range(1, 12), $urandom_range(7) != 0,
                       $urandom_range(7) != 0);
         end else if (kind < 75) begin
            send_frame($urandom_range(13, FRAME_MAX), $urandom_range(7) != 0, 1'b1);
         end else if (kind < 80) begin
            send_frame($urandom_range(FRAME_MAX + 1, FRAME_MAX + 6), 1'b1, 1'b1);
         end else if (kind < 88) begin
            if (!(rx_mode_m == MODE_COLLECT && stored_count == 0)) send_byte(cfg_flag);
            repeat ($urandom_range(0, 4)) send_stuffed(8'($urandom));
            send_byte(cfg_esc);
            send_byte(cfg_flag);
         end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
         end
         n++;
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      logic [7:0] flag_pick;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      send_idle_pct = 28;
      recv_idle_pct = 87;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_default_frames();
      test_stuffing_and_aborts();
      test_short_frames();
      test_register_extremes();

      // sender idles lightly, receiver heavily
      wait_quiet();
      set_config(8'd126, 8'd125, 8'd32, 1'b1, 1'b1);
      test_random_traffic(1, 75);

      // sender idles heavily, receiver lightly
      wait_quiet();
      send_idle_pct = 87;
      recv_idle_pct = 28;
      flag_pick = 8'($urandom);
      set_config(flag_pick, flag_pick ^ 8'($urandom_range(1, 255)), 8'($urandom),
                 1'($urandom), 1'($urandom));
      test_random_traffic(2, 75);

      // full rate both ways
      wait_quiet();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_config(8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1);
      test_random_traffic(3, 75);

      wait_quiet();
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
